// ===== rtl/ttce_pkg.sv =====
// ----------------------------------------------------------------------------
// ttce_pkg
// shared types, codes and constants of the text terminal cursor engine
// ----------------------------------------------------------------------------
`default_nettype none

package ttce_pkg;

   // grid defaults
   localparam int COLUMNS_DEF  = 42;
   localparam int ROWS_DEF     = 24;
   localparam int TAB_STOP_DEF = 4;

   // queue depth between the parts and on the result side
   localparam int FIFO_DEPTH = 2;

   // field widths
   localparam int CMD_W     = 3;
   localparam int BYTE_W    = 8;
   localparam int ACTION_W  = 2;
   localparam int COLUMN_W  = 6;
   localparam int ROW_OUT_W = 5;

   // signed width of cursor plus move amount
   localparam int SUM_W = 10;

   // command codes
   localparam logic [CMD_W-1:0] CMD_PRINT  = 3'd0;
   localparam logic [CMD_W-1:0] CMD_SET_FG = 3'd1;
   localparam logic [CMD_W-1:0] CMD_SET_BG = 3'd2;
   localparam logic [CMD_W-1:0] CMD_MOVE_X = 3'd3;
   localparam logic [CMD_W-1:0] CMD_MOVE_Y = 3'd4;
   localparam logic [CMD_W-1:0] CMD_RESET  = 3'd5;

   // special bytes
   localparam logic [BYTE_W-1:0] CHAR_NUL = 8'd0;
   localparam logic [BYTE_W-1:0] CHAR_TAB = 8'd9;
   localparam logic [BYTE_W-1:0] CHAR_LF  = 8'd10;
   localparam logic [BYTE_W-1:0] CHAR_CR  = 8'd13;

   // color after reset
   localparam logic [BYTE_W-1:0] FG_RESET = 8'd15;
   localparam logic [BYTE_W-1:0] BG_RESET = 8'd0;

   // result actions
   localparam logic [ACTION_W-1:0] ACT_DRAW   = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_SCROLL = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_CLEAR  = 2'd2;

   // classified operations handed from front to back
   typedef enum logic [3:0] {
      OP_PRINT,
      OP_NEWLINE,
      OP_RETURN,
      OP_TAB,
      OP_SET_FG,
      OP_SET_BG,
      OP_MOVE_X,
      OP_MOVE_Y,
      OP_RESET
   } op_type;

   typedef struct packed {
      op_type            op;
      logic [BYTE_W-1:0] arg_a;   // byte, fg color or move amount
      logic [BYTE_W-1:0] arg_b;   // bg color
   } cmd_type;

   typedef struct packed {
      logic [ACTION_W-1:0]  action;
      logic [COLUMN_W-1:0]  column;
      logic [ROW_OUT_W-1:0] row;
      logic [BYTE_W-1:0]    glyph;
      logic [BYTE_W-1:0]    draw_fg;
      logic [BYTE_W-1:0]    draw_bg;
      logic                 last;
   } rsp_type;

endpackage

`default_nettype wire

// ===== rtl/text_terminal_cursor_engine.sv =====
// ----------------------------------------------------------------------------
// text_terminal_cursor_engine
// cursor and color keeper of a character grid, turning commands into draw,
// scroll and clear words
// ----------------------------------------------------------------------------
// path: a command word is registered in the operation queue, then its result
//   word in the result queue, before it is on the result ports
// throughput: one command word per cycle unless full; a printable byte at the
//   position past the last cell gives two result words, holding the back end
// the back end sets the rate: one result word per cycle, none while rsp_full
// reset: synchronous; queues emptied, cursor home, fg 15, bg 0
`default_nettype none

module text_terminal_cursor_engine import ttce_pkg::*; #(
   parameter int COLUMNS  = COLUMNS_DEF,
   parameter int ROWS     = ROWS_DEF,
   parameter int TAB_STOP = TAB_STOP_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   // command side
   input  wire logic                 push,
   output logic                      full,
   input  wire logic [CMD_W-1:0]     req_command,
   input  wire logic [BYTE_W-1:0]    req_char_code,
   input  wire logic [BYTE_W-1:0]    req_fg_color,
   input  wire logic [BYTE_W-1:0]    req_back_color,
   input  wire logic [BYTE_W-1:0]    req_move_amount,
   // result side
   output logic                      empty,
   input  wire logic                 pop,
   output logic [ACTION_W-1:0]       rsp_action,
   output logic [COLUMN_W-1:0]       rsp_column,
   output logic [ROW_OUT_W-1:0]      rsp_row,
   output logic [BYTE_W-1:0]         rsp_glyph,
   output logic [BYTE_W-1:0]         rsp_draw_fg,
   output logic [BYTE_W-1:0]         rsp_draw_bg,
   output logic                      rsp_last
);

   // front to back operation queue
   logic    cmd_valid;
   cmd_type cmd;
   logic    cmd_pop;

   // back end to result queue
   logic    rsp_push;
   rsp_type rsp_in_word;
   logic    rsp_full;
   rsp_type rsp_head;

   // decode and queue; empty commands are dropped here
   ttce_front u_front (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .full        (full),
      .command     (req_command),
      .char_code   (req_char_code),
      .fg_color    (req_fg_color),
      .back_color  (req_back_color),
      .move_amount (req_move_amount),
      .cmd_valid   (cmd_valid),
      .cmd         (cmd),
      .cmd_pop     (cmd_pop)
   );

   // cursor state and result generation, stalls only on a full result queue
   ttce_back #(
      .COLUMNS  (COLUMNS),
      .ROWS     (ROWS),
      .TAB_STOP (TAB_STOP)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .rsp_push  (rsp_push),
      .rsp       (rsp_in_word),
      .rsp_full  (rsp_full)
   );

   // result queue decouples the back end from the consumer
   ttce_fifo #(
      .DEPTH     (FIFO_DEPTH),
      .item_type (rsp_type)
   ) u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (rsp_in_word),
      .full      (rsp_full),
      .pop       (pop),
      .pop_data  (rsp_head),
      .empty     (empty)
   );

   assign rsp_action  = rsp_head.action;
   assign rsp_column  = rsp_head.column;
   assign rsp_row     = rsp_head.row;
   assign rsp_glyph   = rsp_head.glyph;
   assign rsp_draw_fg = rsp_head.draw_fg;
   assign rsp_draw_bg = rsp_head.draw_bg;
   assign rsp_last    = rsp_head.last;

endmodule

`default_nettype wire

// ===== rtl/ttce_fifo.sv =====
// ----------------------------------------------------------------------------
// ttce_fifo
// small first-in first-out queue of words, registered storage
// ----------------------------------------------------------------------------
`default_nettype none

module ttce_fifo import ttce_pkg::*; #(
   parameter int  DEPTH     = FIFO_DEPTH,
   parameter type item_type = cmd_type
) (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     push,
   input  item_type      push_data,
   output logic          full,
   input  wire logic     pop,
   output item_type      pop_data,
   output logic          empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   item_type           store_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff,  count_in;
   logic               do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = store_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/ttce_front.sv =====
// ----------------------------------------------------------------------------
// ttce_front
// takes input words, classifies them and queues operations for the back end
// ----------------------------------------------------------------------------
`default_nettype none

module ttce_front import ttce_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   output logic                   full,
   input  wire logic [CMD_W-1:0]  command,
   input  wire logic [BYTE_W-1:0] char_code,
   input  wire logic [BYTE_W-1:0] fg_color,
   input  wire logic [BYTE_W-1:0] back_color,
   input  wire logic [BYTE_W-1:0] move_amount,
   output logic                   cmd_valid,
   output cmd_type                cmd,
   input  wire logic              cmd_pop
);

   cmd_type decoded;
   logic    keep;
   logic    cmd_empty;

   always_comb begin
      decoded       = '{op: OP_PRINT, arg_a: char_code, arg_b: back_color};
      keep          = 1'b1;
      unique case (command)
         CMD_PRINT: begin
            priority if (char_code == CHAR_NUL) begin
               keep = 1'b0;
            end else if (char_code == CHAR_LF) begin
               decoded.op = OP_NEWLINE;
            end else if (char_code == CHAR_CR) begin
               decoded.op = OP_RETURN;
            end else if (char_code == CHAR_TAB) begin
               decoded.op = OP_TAB;
            end else begin
               decoded.op = OP_PRINT;
            end
         end
         CMD_SET_FG: begin
            decoded.op    = OP_SET_FG;
            decoded.arg_a = fg_color;
         end
         CMD_SET_BG: begin
            decoded.op = OP_SET_BG;
         end
         CMD_MOVE_X: begin
            decoded.op    = OP_MOVE_X;
            decoded.arg_a = move_amount;
         end
         CMD_MOVE_Y: begin
            decoded.op    = OP_MOVE_Y;
            decoded.arg_a = move_amount;
         end
         CMD_RESET: begin
            decoded.op    = OP_RESET;
            decoded.arg_a = fg_color;
         end
         default: begin
            // unused codes have no effect
            keep = 1'b0;
         end
      endcase
   end

   // words with no effect are taken and dropped here
   ttce_fifo #(
      .DEPTH     (FIFO_DEPTH),
      .item_type (cmd_type)
   ) u_cmd_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push && keep),
      .push_data (decoded),
      .full      (full),
      .pop       (cmd_pop),
      .pop_data  (cmd),
      .empty     (cmd_empty)
   );

   assign cmd_valid = !cmd_empty;

endmodule

`default_nettype wire

// ===== rtl/ttce_back.sv =====
// ----------------------------------------------------------------------------
// ttce_back
// holds cursor and colors, carries out queued operations, emits result words
// ----------------------------------------------------------------------------
`default_nettype none

module ttce_back import ttce_pkg::*; #(
   parameter int COLUMNS  = COLUMNS_DEF,
   parameter int ROWS     = ROWS_DEF,
   parameter int TAB_STOP = TAB_STOP_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic cmd_valid,
   input  cmd_type   cmd,
   output logic      cmd_pop,
   output logic      rsp_push,
   output rsp_type   rsp,
   input  wire logic rsp_full
);

   localparam int COL_W = $clog2(COLUMNS);
   localparam int ROW_W = $clog2(ROWS + 1);
   localparam int TAB_W = COL_W + 1;
   localparam logic signed [SUM_W-1:0] COL_MAX = SUM_W'(COLUMNS - 1);
   localparam logic signed [SUM_W-1:0] ROW_MAX = SUM_W'(ROWS - 1);

   // cursor kept as column and row; row equals ROWS only at column 0
   logic [COL_W-1:0]  col_ff, col_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [BYTE_W-1:0] fg_ff,  fg_in;
   logic [BYTE_W-1:0] bg_ff,  bg_in;

   logic [TAB_W-1:0]        tab_next [2**COL_W];
   logic                    at_end;
   logic [ROW_W-1:0]        eff_row;
   logic [TAB_W-1:0]        tab_col;
   logic signed [SUM_W-1:0] amount;
   logic signed [SUM_W-1:0] col_sum;
   logic signed [SUM_W-1:0] row_sum;

   // next tab stop for each column, capped at the row end
   for (genvar c = 0; c < 2**COL_W; c++) begin : g_tab
      localparam int STOP = ((c / TAB_STOP) + 1) * TAB_STOP;
      localparam int CAP  = (STOP > COLUMNS) ? COLUMNS : STOP;
      assign tab_next[c] = TAB_W'(CAP);
   end

   assign at_end  = (row_ff == ROW_W'(ROWS));
   assign eff_row = at_end ? ROW_W'(ROWS - 1) : row_ff;
   assign tab_col = tab_next[col_ff];
   assign amount  = {{(SUM_W - BYTE_W){cmd.arg_a[BYTE_W-1]}}, cmd.arg_a};
   assign col_sum = $signed(SUM_W'(col_ff)) + amount;
   assign row_sum = $signed(SUM_W'(row_ff)) + amount;

   always_comb begin
      col_in   = col_ff;
      row_in   = row_ff;
      fg_in    = fg_ff;
      bg_in    = bg_ff;
      cmd_pop  = 1'b0;
      rsp_push = 1'b0;
      rsp      = '0;
      if (cmd_valid) begin
         unique case (cmd.op)
            OP_PRINT: begin
               if (!rsp_full) begin
                  rsp_push = 1'b1;
                  if (at_end) begin
                     // scroll first; the command stays queued and the draw follows when there is room
                     rsp.action = ACT_SCROLL;
                     row_in     = ROW_W'(ROWS - 1);
                  end else begin
                     rsp.action  = ACT_DRAW;
                     rsp.column  = COLUMN_W'(col_ff);
                     rsp.row     = ROW_OUT_W'(row_ff);
                     rsp.glyph   = cmd.arg_a;
                     rsp.draw_fg = fg_ff;
                     rsp.draw_bg = bg_ff;
                     rsp.last    = 1'b1;
                     cmd_pop     = 1'b1;
                     if (col_ff == COL_W'(COLUMNS - 1)) begin
                        col_in = '0;
                        row_in = row_ff + 1'b1;
                     end else begin
                        col_in = col_ff + 1'b1;
                     end
                  end
               end
            end
            OP_TAB: begin
               if (!at_end || !rsp_full) begin
                  cmd_pop = 1'b1;
                  if (at_end) begin
                     rsp_push   = 1'b1;
                     rsp.action = ACT_SCROLL;
                     rsp.last   = 1'b1;
                  end
                  if (tab_col >= TAB_W'(COLUMNS)) begin
                     col_in = '0;
                     row_in = eff_row + 1'b1;
                  end else begin
                     col_in = tab_col[COL_W-1:0];
                     row_in = eff_row;
                  end
               end
            end
            OP_NEWLINE: begin
               cmd_pop = 1'b1;
               if (col_ff != '0) begin
                  col_in = '0;
                  row_in = row_ff + 1'b1;
               end
            end
            OP_RETURN: begin
               cmd_pop = 1'b1;
               col_in  = '0;
            end
            OP_SET_FG: begin
               cmd_pop = 1'b1;
               fg_in   = cmd.arg_a;
            end
            OP_SET_BG: begin
               cmd_pop = 1'b1;
               bg_in   = cmd.arg_b;
            end
            OP_MOVE_X: begin
               cmd_pop = 1'b1;
               if (!at_end) begin
                  priority if (col_sum < 0) begin
                     col_in = '0;
                  end else if (col_sum > COL_MAX) begin
                     col_in = COL_W'(COLUMNS - 1);
                  end else begin
                     col_in = col_sum[COL_W-1:0];
                  end
               end
            end
            OP_MOVE_Y: begin
               cmd_pop = 1'b1;
               priority if (row_sum < 0) begin
                  row_in = '0;
               end else if (row_sum > ROW_MAX) begin
                  row_in = ROW_W'(ROWS - 1);
               end else begin
                  row_in = row_sum[ROW_W-1:0];
               end
            end
            OP_RESET: begin
               if (!rsp_full) begin
                  cmd_pop     = 1'b1;
                  rsp_push    = 1'b1;
                  rsp.action  = ACT_CLEAR;
                  rsp.draw_bg = cmd.arg_b;
                  rsp.last    = 1'b1;
                  col_in      = '0;
                  row_in      = '0;
                  fg_in       = cmd.arg_a;
                  bg_in       = cmd.arg_b;
               end
            end
            default: begin
               cmd_pop = 1'b1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
         fg_ff  <= FG_RESET;
         bg_ff  <= BG_RESET;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
         fg_ff  <= fg_in;
         bg_ff  <= bg_in;
      end
   end

endmodule

`default_nettype wire
